@@ src/esc_pkg.sv @@
// shared types and constants of the environmental sensor compensation block
`default_nettype none

package esc_pkg;

    localparam int TFINE_LAT = 4;
    localparam int TEMP_LAT  = 5;
    localparam int HUM_LAT   = 8;
    localparam int DIV_BITS  = 41;
    localparam int DD_W      = 38;
    localparam int PRESS_LAT = 6 + DIV_BITS + 4;
    localparam int TOTAL_LAT = TFINE_LAT + PRESS_LAT;
    localparam int TEMP_DLY  = TOTAL_LAT - TEMP_LAT;
    localparam int HUM_DLY   = PRESS_LAT - HUM_LAT;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_TRIM    = 3'd0,
        CFG_PRESS_TRIM_A = 3'd1,
        CFG_PRESS_TRIM_B = 3'd2,
        CFG_MIXED_TRIM   = 3'd3,
        CFG_HUM_TRIM     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic [16:0]        hum_q22_10;
        logic               press_div_zero;
    } out_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } trim_t;

    typedef struct packed {
        logic [DD_W-1:0]     rem;
        logic [DIV_BITS-1:0] nlo;
        logic [DIV_BITS-1:0] quo;
        logic [DD_W-1:0]     dd;
        logic                ovf;
        logic                neg;
        logic                dz;
    } div_t;

endpackage

`default_nettype wire

@@ src/esc_temp.sv @@
// temperature pipeline: fine temperature and hundredths of a degree
`default_nettype none

module esc_temp import esc_pkg::*; (
    input  wire                clk,
    input  wire  [19:0]        raw_temp,
    input  wire  trim_t        trim,
    output logic signed [23:0] tfine,
    output logic signed [31:0] temp_centi
);

    logic signed [18:0] a_reg;
    logic signed [17:0] d_reg;
    logic signed [34:0] m1_reg;
    logic signed [33:0] sq_reg;
    logic signed [23:0] tv1_reg;
    logic signed [36:0] m2_reg;
    logic signed [23:0] tfine_reg;
    logic signed [31:0] temp_reg;
    logic signed [26:0] t5;

    assign t5 = (27'(tfine_reg) <<< 2) + 27'(tfine_reg) + 27'sd128;

    always_ff @(posedge clk)
    begin
        a_reg     <= $signed({2'b0, raw_temp[19:3]}) - $signed({2'b0, trim.t1, 1'b0});
        d_reg     <= $signed({2'b0, raw_temp[19:4]}) - $signed({2'b0, trim.t1});
        m1_reg    <= 35'(a_reg) * 35'(trim.t2);
        sq_reg    <= 34'(d_reg) * 34'(d_reg);
        tv1_reg   <= 24'(m1_reg >>> 11);
        m2_reg    <= 37'(sq_reg >>> 12) * 37'(trim.t3);
        tfine_reg <= tv1_reg + 24'(m2_reg >>> 14);
        temp_reg  <= 32'(t5 >>> 8);
    end

    assign tfine      = tfine_reg;
    assign temp_centi = temp_reg;

endmodule

`default_nettype wire

@@ src/esc_hum.sv @@
// humidity pipeline from fine temperature and raw humidity
`default_nettype none

module esc_hum import esc_pkg::*; (
    input  wire                clk,
    input  wire  signed [23:0] tfine,
    input  wire  [15:0]        raw_hum,
    input  wire  trim_t        trim,
    output logic [16:0]        hum
);

    logic signed [24:0] hv;
    logic signed [40:0] m5_reg;
    logic signed [32:0] m6_reg;
    logic signed [33:0] m3_reg;
    logic [15:0]        adch_reg;
    logic signed [41:0] ha_sum;
    logic signed [26:0] ha_reg;
    logic signed [26:0] ha_d1_reg;
    logic signed [26:0] ha_d2_reg;
    logic signed [22:0] hc_reg;
    logic signed [23:0] he_reg;
    logic signed [46:0] ce_reg;
    logic signed [37:0] x;
    logic signed [53:0] m2h_reg;
    logic signed [39:0] hb;
    logic signed [63:0] hx_reg;
    logic               pos_reg;
    logic               big_reg;
    logic [53:0]        sq_reg;
    logic signed [63:0] hx_d1_reg;
    logic               pos_d_reg;
    logic               big_d_reg;
    logic [54:0]        tsub_reg;
    logic signed [63:0] hx_d2_reg;
    logic signed [64:0] y;
    logic [16:0]        hum_next;
    logic [16:0]        hum_reg;

    assign hv     = 25'(tfine) - 25'sd76800;
    assign ha_sum = 42'($signed({1'b0, adch_reg, 14'b0})) - (42'(trim.h4) <<< 20)
                    - 42'(m5_reg) + 42'sd16384;
    assign x      = 38'(ce_reg >>> 10) + 38'sd2097152;
    assign hb     = 40'((m2h_reg + 54'sd8192) >>> 14);
    assign y      = 65'(hx_d2_reg) - $signed({14'b0, tsub_reg[54:4]});

    always_comb
    begin
        if (!pos_d_reg || big_d_reg || y[64])
        begin
            hum_next = '0;
        end
        else if (y > 65'sd419430400)
        begin
            hum_next = 17'd102400;
        end
        else
        begin
            hum_next = y[28:12];
        end
    end

    always_ff @(posedge clk)
    begin
        m5_reg    <= 41'(hv) * 41'(trim.h5);
        m6_reg    <= 33'(hv) * 33'(trim.h6);
        m3_reg    <= 34'(hv) * 34'($signed({1'b0, trim.h3}));
        adch_reg  <= raw_hum;
        ha_reg    <= 27'(ha_sum >>> 15);
        hc_reg    <= 23'(m6_reg >>> 10);
        he_reg    <= 24'(m3_reg >>> 11) + 24'sd32768;
        ce_reg    <= 47'(hc_reg) * 47'(he_reg);
        ha_d1_reg <= ha_reg;
        m2h_reg   <= 54'(x) * 54'(trim.h2);
        ha_d2_reg <= ha_d1_reg;
        hx_reg    <= 64'(ha_d2_reg) * 64'(hb);
        pos_reg   <= !hx_reg[63] && (hx_reg != '0);
        big_reg   <= (trim.h1 != '0) && (hx_reg[62:42] != '0);
        sq_reg    <= 54'(hx_reg[41:15]) * 54'(hx_reg[41:15]);
        hx_d1_reg <= hx_reg;
        tsub_reg  <= 55'(sq_reg >> 7) * 55'(trim.h1);
        pos_d_reg <= pos_reg;
        big_d_reg <= big_reg;
        hx_d2_reg <= hx_d1_reg;
        hum_reg   <= hum_next;
    end

    assign hum = hum_reg;

endmodule

`default_nettype wire

@@ src/esc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module esc_div import esc_pkg::*; (
    input  wire        clk,
    input  wire  div_t din,
    output div_t       dout
);

    div_t stage_reg [DIV_BITS];

    function automatic div_t div_step(div_t s);
        logic [DD_W:0] trial;
        logic [DD_W:0] diff;
        logic          ge;
        div_t          r;
        begin
            r     = s;
            trial = {s.rem, s.nlo[DIV_BITS-1]};
            diff  = trial - {1'b0, s.dd};
            ge    = trial >= {1'b0, s.dd};
            r.rem = ge ? diff[DD_W-1:0] : trial[DD_W-1:0];
            r.nlo = {s.nlo[DIV_BITS-2:0], 1'b0};
            r.quo = {s.quo[DIV_BITS-2:0], ge};
            return r;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= div_step(din);
        for (int i = 1; i < DIV_BITS; i++)
        begin
            stage_reg[i] <= div_step(stage_reg[i-1]);
        end
    end

    assign dout = stage_reg[DIV_BITS-1];

endmodule

`default_nettype wire

@@ src/esc_press.sv @@
// pressure pipeline: divisor, numerator, divider and second-order correction
`default_nettype none

module esc_press import esc_pkg::*; (
    input  wire                clk,
    input  wire  signed [23:0] tfine,
    input  wire  [19:0]        raw_press,
    input  wire  trim_t        trim,
    output logic [31:0]        press,
    output logic               div_zero
);

    logic signed [24:0] v;
    logic signed [49:0] vv_reg;
    logic signed [40:0] v5_reg;
    logic signed [40:0] v2_reg;
    logic signed [63:0] a6_reg;
    logic signed [63:0] a3_reg;
    logic signed [40:0] b5_reg;
    logic signed [40:0] b2_reg;
    logic signed [63:0] var2_reg;
    logic signed [55:0] var1_reg;
    logic signed [55:0] xd;
    logic signed [72:0] dprod_reg;
    logic signed [63:0] var2_d_reg;
    logic [19:0]        adcp_reg [4];
    logic signed [39:0] dv;
    logic signed [39:0] dv_abs;
    logic [20:0]        diffp;
    logic signed [63:0] num;
    logic signed [63:0] num_abs;
    logic [62:0]        n_reg;
    logic [DD_W-1:0]    dd_reg;
    logic               neg_reg;
    logic               dz_reg;
    logic [74:0]        nq;
    div_t               div_in_reg;
    div_t               div_out;
    logic [DIV_BITS-1:0] mag;
    logic signed [41:0] qs_reg;
    logic               dz1_reg;
    logic signed [28:0] s;
    logic signed [57:0] ss_reg;
    logic signed [38:0] p8q_reg;
    logic signed [41:0] qs2_reg;
    logic               dz2_reg;
    logic signed [48:0] corr_reg;
    logic signed [38:0] p8q_d_reg;
    logic signed [41:0] qs3_reg;
    logic               dz3_reg;
    logic signed [49:0] psum;
    logic signed [42:0] res;
    logic [31:0]        press_next;
    logic [31:0]        press_reg;
    logic               dz_out_reg;

    assign v       = 25'(tfine) - 25'sd128000;
    assign xd      = var1_reg + (56'sd1 <<< 47);
    assign dv      = 40'(dprod_reg >>> 33);
    assign dv_abs  = dv[39] ? -dv : dv;
    assign diffp   = 21'h100000 - {1'b0, adcp_reg[3]};
    assign num     = 64'($signed({1'b0, diffp, 31'b0})) - var2_d_reg;
    assign num_abs = num[63] ? -num : num;
    assign nq      = 75'(n_reg) * 75'(3125);
    assign mag     = div_out.ovf ? '1 : div_out.quo;
    assign s       = 29'(qs_reg >>> 13);
    assign psum    = 50'(qs3_reg) + 50'(corr_reg) + 50'(p8q_d_reg);
    assign res     = 43'(psum >>> 8) + (43'(trim.p7) <<< 4);

    always_comb
    begin
        if (dz3_reg || res[42])
        begin
            press_next = '0;
        end
        else if (res[41:32] != '0)
        begin
            press_next = '1;
        end
        else
        begin
            press_next = res[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        vv_reg      <= 50'(v) * 50'(v);
        v5_reg      <= 41'(v) * 41'(trim.p5);
        v2_reg      <= 41'(v) * 41'(trim.p2);
        adcp_reg[0] <= raw_press;
        for (int i = 1; i < 4; i++)
        begin
            adcp_reg[i] <= adcp_reg[i-1];
        end
        a6_reg      <= 64'(vv_reg) * 64'(trim.p6);
        a3_reg      <= 64'(vv_reg) * 64'(trim.p3);
        b5_reg      <= v5_reg;
        b2_reg      <= v2_reg;
        var2_reg    <= a6_reg + (64'(b5_reg) <<< 17) + (64'(trim.p4) <<< 35);
        var1_reg    <= 56'(a3_reg >>> 8) + (56'(b2_reg) <<< 12);
        dprod_reg   <= 73'(xd) * 73'($signed({1'b0, trim.p1}));
        var2_d_reg  <= var2_reg;
        n_reg       <= num_abs[62:0];
        dd_reg      <= dv_abs[DD_W-1:0];
        neg_reg     <= num[63] ^ dv[39];
        dz_reg      <= dv == '0;
        div_in_reg.rem <= {4'b0, nq[74:41]};
        div_in_reg.nlo <= nq[40:0];
        div_in_reg.quo <= '0;
        div_in_reg.dd  <= dd_reg;
        div_in_reg.ovf <= {4'b0, nq[74:41]} >= dd_reg;
        div_in_reg.neg <= neg_reg;
        div_in_reg.dz  <= dz_reg;
        qs_reg      <= div_out.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        dz1_reg     <= div_out.dz;
        ss_reg      <= 58'(s) * 58'(s);
        p8q_reg     <= 39'((58'(qs_reg) * 58'(trim.p8)) >>> 19);
        qs2_reg     <= qs_reg;
        dz2_reg     <= dz1_reg;
        corr_reg    <= 49'((74'(ss_reg) * 74'(trim.p9)) >>> 25);
        p8q_d_reg   <= p8q_reg;
        qs3_reg     <= qs2_reg;
        dz3_reg     <= dz2_reg;
        press_reg   <= press_next;
        dz_out_reg  <= dz3_reg;
    end

    esc_div u_div (
        .clk  (clk),
        .din  (div_in_reg),
        .dout (div_out)
    );

    assign press    = press_reg;
    assign div_zero = dz_out_reg;

endmodule

`default_nettype wire

@@ src/env_sensor_compensation.sv @@
// top level of the environmental sensor compensation block
//
//  port group                      | dir | what moves
//  start, busy, sample             | in  | raw reading, transfer when start && !busy
//  done, result                    | out | compensated reading, one-cycle strobe
//  cfg_we, cfg_index, cfg_data     | in  | trim word write, no wait
//
//  one reading is taken every cycle; busy stays low
//  result timing is set by the 41-stage divider
//  of the pressure path plus the polynomial stages before and after it
//  reset clears the trim words and the valid pipe; datapath registers are not reset
//  the receiver cannot stall, so the pipeline never holds
`default_nettype none

module env_sensor_compensation import esc_pkg::*; (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  in_t            sample,
    output logic                 done,
    output out_t                 result,
    input  wire                  cfg_we,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [CFG_W-1:0]     cfg_data
);

    typedef struct packed {
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } raw_t;

    logic [47:0]        temp_trim_reg;
    logic [63:0]        press_trim_a_reg;
    logic [63:0]        press_trim_b_reg;
    logic [47:0]        mixed_trim_reg;
    logic [39:0]        hum_trim_reg;
    trim_t              trim;
    logic [TOTAL_LAT:0] valid_reg;
    in_t                sample_reg;
    raw_t               raw_dly_reg [TFINE_LAT];
    logic signed [23:0] tfine;
    logic signed [31:0] temp_centi;
    logic signed [31:0] temp_dly_reg [TEMP_DLY];
    logic [16:0]        hum;
    logic [16:0]        hum_dly_reg [HUM_DLY];
    logic [31:0]        press;
    logic               div_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg    <= '0;
            press_trim_a_reg <= '0;
            press_trim_b_reg <= '0;
            mixed_trim_reg   <= '0;
            hum_trim_reg     <= '0;
            valid_reg        <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[TOTAL_LAT-1:0], start};
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP_TRIM:    temp_trim_reg    <= cfg_data[47:0];
                    CFG_PRESS_TRIM_A: press_trim_a_reg <= cfg_data;
                    CFG_PRESS_TRIM_B: press_trim_b_reg <= cfg_data;
                    CFG_MIXED_TRIM:   mixed_trim_reg   <= cfg_data[47:0];
                    CFG_HUM_TRIM:     hum_trim_reg     <= cfg_data[39:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        trim.t1 = temp_trim_reg[15:0];
        trim.t2 = temp_trim_reg[31:16];
        trim.t3 = temp_trim_reg[47:32];
        trim.p1 = press_trim_a_reg[15:0];
        trim.p2 = press_trim_a_reg[31:16];
        trim.p3 = press_trim_a_reg[47:32];
        trim.p4 = press_trim_a_reg[63:48];
        trim.p5 = press_trim_b_reg[15:0];
        trim.p6 = press_trim_b_reg[31:16];
        trim.p7 = press_trim_b_reg[47:32];
        trim.p8 = press_trim_b_reg[63:48];
        trim.p9 = mixed_trim_reg[15:0];
        trim.h1 = mixed_trim_reg[23:16];
        trim.h2 = mixed_trim_reg[39:24];
        trim.h3 = mixed_trim_reg[47:40];
        trim.h4 = hum_trim_reg[15:0];
        trim.h5 = hum_trim_reg[31:16];
        trim.h6 = hum_trim_reg[39:32];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= sample;
        end
        raw_dly_reg[0].raw_press <= sample_reg.raw_press;
        raw_dly_reg[0].raw_hum   <= sample_reg.raw_hum;
        for (int i = 1; i < TFINE_LAT; i++)
        begin
            raw_dly_reg[i] <= raw_dly_reg[i-1];
        end
        temp_dly_reg[0] <= temp_centi;
        for (int i = 1; i < TEMP_DLY; i++)
        begin
            temp_dly_reg[i] <= temp_dly_reg[i-1];
        end
        hum_dly_reg[0] <= hum;
        for (int i = 1; i < HUM_DLY; i++)
        begin
            hum_dly_reg[i] <= hum_dly_reg[i-1];
        end
    end

    esc_temp u_temp (
        .clk        (clk),
        .raw_temp   (sample_reg.raw_temp),
        .trim       (trim),
        .tfine      (tfine),
        .temp_centi (temp_centi)
    );

    esc_hum u_hum (
        .clk     (clk),
        .tfine   (tfine),
        .raw_hum (raw_dly_reg[TFINE_LAT-1].raw_hum),
        .trim    (trim),
        .hum     (hum)
    );

    esc_press u_press (
        .clk       (clk),
        .tfine     (tfine),
        .raw_press (raw_dly_reg[TFINE_LAT-1].raw_press),
        .trim      (trim),
        .press     (press),
        .div_zero  (div_zero)
    );

    assign busy = 1'b0;
    assign done = valid_reg[TOTAL_LAT];

    always_comb
    begin
        result.temp_centi     = temp_dly_reg[TEMP_DLY-1];
        result.press_q24_8    = press;
        result.hum_q22_10     = hum_dly_reg[HUM_DLY-1];
        result.press_div_zero = div_zero;
    end

    // a result only follows an accepted reading, whose start has passed through the valid pipe
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT + 1))
        else $error("result without a matching transfer");

    a_div_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.press_div_zero) |-> (result.press_q24_8 == '0))
        else $error("zero divisor with nonzero pressure");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hum_q22_10 <= 17'd102400))
        else $error("humidity above clamp");

endmodule

`default_nettype wire

@@ tb/sv/env_sensor_compensation_tb.sv @@
// self-checking testbench of the environmental sensor compensation block
`timescale 1ns / 1ps

module env_sensor_compensation_tb;
    import esc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_t                  sample;
    logic                 done;
    out_t                 result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [63:0] trim_word [0:4];
    out_t        pending_readings [$];
    bit          idling_on;
    int          n_sent;
    int          n_checked;
    int          n_errors;
    int          n_div_zero;
    int          n_settings;

    env_sensor_compensation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint mul_floor_shift(longint a, longint m, int sh);
        longint hi;
        longint lo;
        hi = a >>> sh;
        lo = a - (hi <<< sh);
        return hi * m + ((lo * m) >>> sh);
    endfunction

    function automatic out_t compensate(in_t s);
        longint at, ap, ah;
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6;
        longint d, tfine, temp, v, var1, var2, dv, num, mag, q, sq, res;
        longint hv, ha, hc, he, hb, hx, hs, hum;
        longint unsigned n, dd, q1, r1;
        out_t r;
        at = longint'(s.raw_temp);
        ap = longint'(s.raw_press);
        ah = longint'(s.raw_hum);
        t1 = longint'(trim_word[CFG_TEMP_TRIM][15:0]);
        t2 = longint'(signed'(trim_word[CFG_TEMP_TRIM][31:16]));
        t3 = longint'(signed'(trim_word[CFG_TEMP_TRIM][47:32]));
        p1 = longint'(trim_word[CFG_PRESS_TRIM_A][15:0]);
        p2 = longint'(signed'(trim_word[CFG_PRESS_TRIM_A][31:16]));
        p3 = longint'(signed'(trim_word[CFG_PRESS_TRIM_A][47:32]));
        p4 = longint'(signed'(trim_word[CFG_PRESS_TRIM_A][63:48]));
        p5 = longint'(signed'(trim_word[CFG_PRESS_TRIM_B][15:0]));
        p6 = longint'(signed'(trim_word[CFG_PRESS_TRIM_B][31:16]));
        p7 = longint'(signed'(trim_word[CFG_PRESS_TRIM_B][47:32]));
        p8 = longint'(signed'(trim_word[CFG_PRESS_TRIM_B][63:48]));
        p9 = longint'(signed'(trim_word[CFG_MIXED_TRIM][15:0]));
        h1 = longint'(trim_word[CFG_MIXED_TRIM][23:16]);
        h2 = longint'(signed'(trim_word[CFG_MIXED_TRIM][39:24]));
        h3 = longint'(trim_word[CFG_MIXED_TRIM][47:40]);
        h4 = longint'(signed'(trim_word[CFG_HUM_TRIM][15:0]));
        h5 = longint'(signed'(trim_word[CFG_HUM_TRIM][31:16]));
        h6 = longint'(signed'(trim_word[CFG_HUM_TRIM][39:32]));

        d = (at >>> 4) - t1;
        tfine = ((((at >>> 3) - t1 * 2) * t2) >>> 11) + ((((d * d) >>> 12) * t3) >>> 14);
        temp = (tfine * 5 + 128) >>> 8;
        r.temp_centi = temp[31:0];

        v = tfine - 128000;
        var2 = v * v * p6 + ((v * p5) <<< 17) + (p4 <<< 35);
        var1 = ((v * v * p3) >>> 8) + v * p2 * 4096;
        dv = mul_floor_shift((64'sd1 <<< 47) + var1, p1, 33);
        if (dv == 0)
        begin
            r.press_q24_8 = '0;
            r.press_div_zero = 1'b1;
        end
        else
        begin
            num = ((1048576 - ap) <<< 31) - var2;
            n = (num < 0) ? longint'(-num) : num;
            dd = (dv < 0) ? longint'(-dv) : dv;
            q1 = n / dd;
            r1 = n % dd;
            if (q1 >= (64'd1 << 41))
                mag = (64'sd1 <<< 41) - 1;
            else
            begin
                mag = longint'(q1 * 3125 + (r1 * 3125) / dd);
                if (mag > (64'sd1 <<< 41) - 1)
                    mag = (64'sd1 <<< 41) - 1;
            end
            q = ((num < 0) != (dv < 0)) ? -mag : mag;
            sq = q >>> 13;
            res = ((q + mul_floor_shift(sq * sq, p9, 25) + ((p8 * q) >>> 19)) >>> 8) + p7 * 16;
            if (res < 0)
                r.press_q24_8 = '0;
            else if (res > 64'sd4294967295)
                r.press_q24_8 = '1;
            else
                r.press_q24_8 = res[31:0];
            r.press_div_zero = 1'b0;
        end

        hv = tfine - 76800;
        ha = (ah * 16384 - (h4 <<< 20) - h5 * hv + 16384) >>> 15;
        hc = (hv * h6) >>> 10;
        he = ((hv * h3) >>> 11) + 32768;
        hb = ((((hc * he) >>> 10) + 2097152) * h2 + 8192) >>> 14;
        hx = ha * hb;
        if (hx <= 0)
            hum = 0;
        else
        begin
            hs = hx >>> 15;
            if (h1 != 0 && hs >= (64'sd1 <<< 27))
                hum = 0;
            else
            begin
                if (h1 != 0)
                    hx = hx - ((((hs * hs) >>> 7) * h1) >>> 4);
                if (hx < 0)
                    hx = 0;
                if (hx > 419430400)
                    hx = 419430400;
                hum = hx >>> 12;
            end
        end
        r.hum_q22_10 = hum[16:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_t exp_r;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result with no transfer outstanding: %h", result);
                n_errors++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                n_checked++;
                if (exp_r.press_div_zero)
                    n_div_zero++;
                if (result.temp_centi !== exp_r.temp_centi)
                begin
                    $error("temp_centi expected %0d actual %0d",
                           exp_r.temp_centi, result.temp_centi);
                    n_errors++;
                end
                if (result.press_q24_8 !== exp_r.press_q24_8)
                begin
                    $error("press_q24_8 expected %0d actual %0d",
                           exp_r.press_q24_8, result.press_q24_8);
                    n_errors++;
                end
                if (result.hum_q22_10 !== exp_r.hum_q22_10)
                begin
                    $error("hum_q22_10 expected %0d actual %0d",
                           exp_r.hum_q22_10, result.hum_q22_10);
                    n_errors++;
                end
                if (result.press_div_zero !== exp_r.press_div_zero)
                begin
                    $error("press_div_zero expected %0b actual %0b",
                           exp_r.press_div_zero, result.press_div_zero);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        in_t s;
        s.raw_temp  = rt;
        s.raw_press = rp;
        s.raw_hum   = rh;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        pending_readings.push_back(compensate(s));
        n_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 4) @(posedge clk);
    endtask

    task automatic write_trim(cfg_reg_t idx, logic [63:0] value);
        case (idx)
            CFG_TEMP_TRIM, CFG_MIXED_TRIM: value[63:48] = '0;
            CFG_HUM_TRIM:                  value[63:40] = '0;
            default: ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        trim_word[idx] = value;
    endtask

    task automatic load_trims(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                              logic [63:0] w3, logic [63:0] w4);
        write_trim(CFG_TEMP_TRIM, w0);
        write_trim(CFG_PRESS_TRIM_A, w1);
        write_trim(CFG_PRESS_TRIM_B, w2);
        write_trim(CFG_MIXED_TRIM, w3);
        write_trim(CFG_HUM_TRIM, w4);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // typical factory trim set
    task automatic load_typical_trims();
        load_trims({16'd0, -16'sd1000, 16'sd26435, 16'd27504},
                   {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
                   {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
                   {8'd0, 16'sd362, 8'd75, 16'sd6000},
                   {8'sd30, 16'sd50, 16'sd313});
    endtask

    task automatic load_random_trims();
        logic [63:0] w [0:4];
        for (int i = 0; i < 5; i++)
            w[i] = {$urandom(), $urandom()};
        // mostly plausible sets, with random low-order perturbation
        if ($urandom_range(0, 3) != 0)
        begin
            w[0][15:0]  = 16'd27504 + 16'($urandom_range(0, 4000)) - 16'd2000;
            w[0][31:16] = 16'($urandom_range(20000, 30000));
            w[0][47:32] = 16'($urandom_range(0, 100)) - 16'd1050;
            w[1][15:0]  = 16'($urandom_range(30000, 40000));
            w[1][31:16] = -16'sd10685 + 16'($urandom_range(0, 200));
            w[1][47:32] = 16'($urandom_range(2000, 4000));
            w[1][63:48] = 16'($urandom_range(2000, 8000));
            w[2][15:0]  = 16'($urandom_range(0, 300));
            w[2][31:16] = 16'($urandom_range(0, 14)) - 16'd7;
            w[2][47:32] = 16'($urandom_range(14000, 16000));
            w[2][63:48] = -16'sd14600 + 16'($urandom_range(0, 500));
            w[3][15:0]  = 16'($urandom_range(4000, 8000));
            w[3][39:24] = 16'($urandom_range(300, 400));
            w[4][15:0]  = 16'($urandom_range(250, 350));
            w[4][31:16] = 16'($urandom_range(0, 100));
            w[4][39:32] = 8'($urandom_range(0, 60));
        end
        load_trims(w[0], w[1], w[2], w[3], w[4]);
    endtask

    task automatic send_random_reading();
        if ($urandom_range(0, 3) != 0)
            send_reading(20'd519888 + 20'($urandom_range(0, 200000)) - 20'd100000,
                         20'd415148 + 20'($urandom_range(0, 200000)) - 20'd100000,
                         16'($urandom_range(20000, 40000)));
        else
            send_reading(20'($urandom()), 20'($urandom()), 16'($urandom()));
    endtask

    task automatic test_reset_trims();
        send_reading(20'd0, 20'd0, 16'd0);
        send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_reading(20'd519888, 20'd415148, 16'd30000);
        wait_drained();
    endtask

    task automatic test_typical_and_extremes();
        load_typical_trims();
        send_reading(20'd519888, 20'd415148, 16'd30000);
        send_reading(20'd0, 20'd0, 16'd0);
        send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_reading(20'd0, 20'hFFFFF, 16'hFFFF);
        send_reading(20'hFFFFF, 20'd0, 16'd0);
        send_reading(20'd440064, 20'd1048575, 16'd0);
        send_reading(20'd519888, 20'd1, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_trim_extremes();
        load_trims('1, '1, '1, '1, '1);
        send_reading(20'd519888, 20'd415148, 16'd30000);
        send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
        wait_drained();
        load_trims({16'd0, 16'h8000, 16'h7FFF, 16'hFFFF},
                   {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                   {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                   {8'hFF, 16'h8000, 8'hFF, 16'h7FFF},
                   {8'h80, 16'h7FFF, 16'h8000});
        send_reading(20'd0, 20'd0, 16'd0);
        send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_reading(20'd519888, 20'd415148, 16'd30000);
        wait_drained();
        // saturating pressure and humidity limits
        load_trims({16'd0, -16'sd1000, 16'sd26435, 16'd27504},
                   {16'sd2855, 16'sd3024, -16'sd10685, 16'd1},
                   {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
                   {8'd0, 16'h7FFF, 8'd0, 16'h7FFF},
                   {8'sd30, 16'sd0, 16'h8000});
        send_reading(20'd519888, 20'd0, 16'hFFFF);
        send_reading(20'd519888, 20'hFFFFF, 16'd0);
        wait_drained();
    endtask

    task automatic test_random_readings(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                wait_drained();
                load_random_trims();
            end
            if (i == count - 300)
                idling_on = 1'b0;
            send_random_reading();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        sample     = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idling_on  = 1'b1;
        n_sent     = 0;
        n_checked  = 0;
        n_errors   = 0;
        n_div_zero = 0;
        n_settings = 1;
        for (int i = 0; i < 5; i++)
            trim_word[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_trims();
        test_typical_and_extremes();
        test_trim_extremes();
        test_random_readings(1800);
        wait_drained();

        $display("covered %0d readings over %0d trim settings, %0d results checked",
                 n_sent, n_settings, n_checked);
        $display("zero-divisor results seen: %0d", n_div_zero);
        if (n_errors == 0 && pending_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
